@@ hdl/bnd_pkg.sv @@
// ============================================================================
// bnd_pkg
// Shared types and constants for the BGGR nearest-neighbor demosaic block.
// ============================================================================
package bnd_pkg;

  localparam int SAMPLE_W = 8;
  localparam int COORD_W  = 11;
  localparam int CFG_W    = 12;

  // Register indexes on the configuration port.
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Beat position within one quad; the fourth beat carries quad_last.
  localparam logic [1:0] PHASE_LAST = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] in_red;
    logic [SAMPLE_W-1:0] in_green;
    logic [SAMPLE_W-1:0] in_blue;
  } in_beat_t;

  typedef struct packed {
    logic [COORD_W-1:0]  pix_x;
    logic [COORD_W-1:0]  pix_y;
    logic [SAMPLE_W-1:0] out_red;
    logic [SAMPLE_W-1:0] out_green;
    logic [SAMPLE_W-1:0] out_blue;
    logic                quad_last;
  } out_beat_t;

  // One finished quad: coordinates of its odd (red) corner and its samples.
  typedef struct packed {
    logic [COORD_W-1:0]  x_odd;
    logic [COORD_W-1:0]  y_odd;
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] blue;
    logic [SAMPLE_W-1:0] top_green;
    logic [SAMPLE_W-1:0] low_green;
  } quad_t;

  typedef struct packed {
    logic  valid;
    quad_t quad;
  } quad_push_t;

  typedef struct packed {
    logic  empty;
    logic  full;
    quad_t head;
  } queue_stat_t;

endpackage

@@ hdl/bnd_ram.sv @@
// ============================================================================
// bnd_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module bnd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/bnd_front.sv @@
// ============================================================================
// bnd_front
// Accepts pixels, tracks raster position, keeps the even-row line buffer
// and hands each completed quad to the queue.
// ============================================================================
module bnd_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [bnd_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bnd_pkg::in_beat_t             in_data,
  input  bnd_pkg::queue_stat_t          q_stat,
  output bnd_pkg::quad_push_t           q_push
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int PAIRS = (MAX_WIDTH + 1) / 2;
  localparam int AW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int CMPW  = ((CW > RW ? CW : RW) > bnd_pkg::CFG_W ?
                          (CW > RW ? CW : RW) : bnd_pkg::CFG_W) + 1;
  localparam int SW    = bnd_pkg::SAMPLE_W;

  logic [bnd_pkg::CFG_W-1:0] width_r, height_r;
  logic [CW-1:0]             col_r, col_nxt;
  logic [RW-1:0]             row_r, row_nxt;
  logic [SW-1:0]             held_blue_r;
  logic [SW-1:0]             held_green_r;

  logic          accept, emits, col_end, row_end;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [2*SW-1:0] ram_wdata, ram_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bnd_pkg::CFG_W'(640);
      height_r <= bnd_pkg::CFG_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bnd_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        bnd_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign emits    = row_r[0] & col_r[0];
  assign in_ready = ~emits | ~q_stat.full;
  assign accept   = in_valid & in_ready;

  assign col_end = (CMPW'(col_r) + CMPW'(1) >= CMPW'(width_r)) ||
                   (col_r == CW'(MAX_WIDTH - 1));
  assign row_end = (CMPW'(row_r) + CMPW'(1) >= CMPW'(height_r)) ||
                   (row_r == RW'(MAX_HEIGHT - 1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      held_green_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (accept && row_r[0] && !col_r[0]) begin
        held_green_r <= in_data.in_green;
      end
    end
  end

  // Blue of an even-row pair waits here until its green partner arrives.
  always_ff @(posedge clk) begin
    if (accept && !row_r[0] && !col_r[0]) begin
      held_blue_r <= in_data.in_blue;
    end
  end

  // Each line buffer word holds one column pair: green high, blue low.
  assign ram_addr  = AW'(col_r >> 1);
  assign ram_we    = accept & ~row_r[0] & col_r[0];
  assign ram_wdata = {in_data.in_green, held_blue_r};
  // The pair is fetched on the odd row's even column; read data holds
  // until the matching odd column arrives.
  assign ram_re    = accept & row_r[0] & ~col_r[0];

  bnd_ram #(
    .WIDTH (2 * SW),
    .DEPTH (PAIRS)
  ) u_line_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    q_push.valid          = accept & emits;
    q_push.quad.x_odd     = bnd_pkg::COORD_W'(col_r);
    q_push.quad.y_odd     = bnd_pkg::COORD_W'(row_r);
    q_push.quad.red       = in_data.in_red;
    q_push.quad.blue      = ram_rdata[SW-1:0];
    q_push.quad.top_green = ram_rdata[2*SW-1:SW];
    q_push.quad.low_green = held_green_r;
  end

endmodule

@@ hdl/bnd_queue.sv @@
// ============================================================================
// bnd_queue
// Two-entry queue of finished quads between the front and back parts.
// ============================================================================
module bnd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bnd_pkg::quad_push_t  q_push,
  input  logic                 pop,
  output bnd_pkg::queue_stat_t q_stat
);

  bnd_pkg::quad_t entry_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     count_r;
  logic           do_push, do_pop;

  assign do_push = q_push.valid & (count_r != 2'd2);
  assign do_pop  = pop & (count_r != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= q_push.quad;
    end
  end

  assign q_stat.empty = (count_r == 2'd0);
  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.head  = entry_r[rd_ptr_r];

endmodule

@@ hdl/bnd_back.sv @@
// ============================================================================
// bnd_back
// Expands each queued quad into four output pixels through an output
// register.
// ============================================================================
module bnd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bnd_pkg::queue_stat_t q_stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bnd_pkg::out_beat_t   out_data
);

  logic [1:0]         phase_r;
  logic               out_valid_r;
  bnd_pkg::out_beat_t out_data_r, beat;
  logic               load;

  assign load = ~q_stat.empty & (~out_valid_r | out_ready);
  assign pop  = load & (phase_r == bnd_pkg::PHASE_LAST);

  // Phase bit 0 selects the right column, bit 1 the lower row.
  always_comb begin
    beat.pix_x     = {q_stat.head.x_odd[bnd_pkg::COORD_W-1:1], phase_r[0]};
    beat.pix_y     = {q_stat.head.y_odd[bnd_pkg::COORD_W-1:1], phase_r[1]};
    beat.out_red   = q_stat.head.red;
    beat.out_blue  = q_stat.head.blue;
    beat.out_green = phase_r[1] ? q_stat.head.low_green : q_stat.head.top_green;
    beat.quad_last = (phase_r == bnd_pkg::PHASE_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        phase_r     <= phase_r + 2'd1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/bayer_nearest_neighbor_demosaic_top.sv @@
// ============================================================================
// bayer_nearest_neighbor_demosaic_top
// Streaming BGGR nearest-neighbor demosaic with a single line buffer.
// ============================================================================
// Full-color pixels enter in raster order on the in_ channel, one per beat.
// Of each pixel only its Bayer sample is kept (blue at even row and even
// column, red at odd row and odd column, green elsewhere). Each 2x2 quad is
// rebuilt from its own samples and leaves as four out_ beats in the order
// top-left, top-right, bottom-left, bottom-right; the fourth carries
// quad_last. A trailing odd column or row is dropped. The input side takes
// one beat per cycle while in_ready is high; on even rows nothing is
// produced, while on odd rows each column pair yields four output beats, so
// odd rows are throttled by the single output register, which drains one
// pixel per cycle while out_ready is high. A two-quad queue lets input and
// output stall independently, and an input beat that does not finish a
// quad is accepted even when the queue is full. The line buffer is one RAM
// word per column pair with a registered read; no clearing pass is needed.
// Write image_width and image_height only while the block is idle.
// ============================================================================
module bayer_nearest_neighbor_demosaic_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [bnd_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bnd_pkg::in_beat_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bnd_pkg::out_beat_t        out_data
);

  // Quads travel from the front part to the back part through the queue.
  bnd_pkg::quad_push_t  q_push;
  bnd_pkg::queue_stat_t q_stat;
  logic                 q_pop;

  // The front part counts raster position and owns the line buffer.
  bnd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .q_push    (q_push)
  );

  bnd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (q_pop),
    .q_stat (q_stat)
  );

  // The back part turns each quad into four pixel beats.
  bnd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The front part must never finish a quad while the queue is full.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.valid |-> !q_stat.full)
    else $error("quad pushed into a full queue");

  // The last beat of a quad is always the red, odd-odd corner.
  a_last_is_red_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.quad_last) |-> (out_data.pix_x[0] && out_data.pix_y[0]))
    else $error("quad_last on a pixel that is not the red corner");

  // Output starts after idle only on the first pixel of a quad.
  a_start_on_quad_head: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (!out_data.pix_x[0] && !out_data.pix_y[0] &&
                          !out_data.quad_last))
    else $error("output resumed in the middle of a quad");

endmodule
